// ----- src/prd_pkg.sv -----
package prd_pkg;

  // Fixed widths of the sensor path
  localparam int SMP_W   = 12;
  localparam int SUM_W   = 16;
  localparam int TICK_W  = 16;
  localparam int MS_W    = 10;
  localparam int BPM_W   = 8;
  localparam int WIN_W   = 6;
  localparam int JUMP_W  = 11;

  // Group and window sizes
  localparam int GROUP    = 10;
  localparam int WINDOW   = 50;
  localparam int CNT_W    = $clog2(GROUP);
  localparam int TRIM_DIV = GROUP - 2;

  // Reset values
  localparam int ADC_MAX         = 4095;
  localparam int TICK_MS_RST     = 20;
  localparam int BPM_FLOOR_RST   = 30;
  localparam int BPM_CEILING_RST = 200;

  // Rate divider: 16-bit dividend and quotient, divisor wide enough for an interval
  localparam int QUO_W      = 16;
  localparam int IVL_W      = TICK_W + MS_W;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam int MS_PER_MIN = 60000;

  // Queue of group numerators between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_MS     = 2'd0,
    CFG_BPM_FLOOR   = 2'd1,
    CFG_BPM_CEILING = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [MS_W-1:0]  tick_ms;
    logic [BPM_W-1:0] bpm_floor;
    logic [BPM_W-1:0] bpm_ceiling;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [IVL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- src/prd_front.sv -----
module prd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [prd_pkg::SMP_W-1:0]  adc_sample_i,
  input  logic                       fifo_full_i,
  output logic                       push_o,
  output logic [prd_pkg::SUM_W-1:0]  push_data_o
);
  import prd_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SMP_W-1:0] min_q, min_d;
  logic [SMP_W-1:0] max_q, max_d;

  logic             accept;
  logic             last;
  logic [SUM_W-1:0] sum_n;
  logic [SMP_W-1:0] min_n, max_n;

  // Take samples only while the queue can hold a finished group
  assign in_ready_o = ~fifo_full_i;
  assign accept     = in_valid_i & ~fifo_full_i;

  // Running group statistics including this beat
  assign sum_n = sum_q + SUM_W'(adc_sample_i);
  assign min_n = (adc_sample_i < min_q) ? adc_sample_i : min_q;
  assign max_n = (adc_sample_i > max_q) ? adc_sample_i : max_q;
  assign last  = (count_q == CNT_W'(GROUP - 1));

  // Trimmed numerator goes to the back on the last sample of a group
  assign push_o      = accept & last;
  assign push_data_o = sum_n - SUM_W'(min_n) - SUM_W'(max_n);

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    min_d   = min_q;
    max_d   = max_q;
    if (accept) begin
      if (last) begin
        count_d = '0;
        sum_d   = '0;
        min_d   = SMP_W'(ADC_MAX);
        max_d   = '0;
      end else begin
        count_d = count_q + CNT_W'(1);
        sum_d   = sum_n;
        min_d   = min_n;
        max_d   = max_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      min_q   <= SMP_W'(ADC_MAX);
      max_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

endmodule

// ----- src/prd_fifo.sv -----
module prd_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [prd_pkg::SUM_W-1:0]  push_data_i,
  input  logic                       pop_i,
  output logic [prd_pkg::SUM_W-1:0]  pop_data_o,
  output logic                       full_o,
  output logic                       empty_o
);
  import prd_pkg::*;

  logic [SUM_W-1:0]   mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   fill_q, fill_d;
  logic               do_push, do_pop;

  assign full_o     = (fill_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + FIFO_AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + (FIFO_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/prd_div.sv -----
module prd_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prd_pkg::div_req_t     req_i,
  output prd_pkg::div_rsp_t     rsp_o
);
  import prd_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IVL_W-1:0]  rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [IVL_W-1:0]  dvs_q, dvs_d;

  logic [IVL_W:0]    rem_sh;
  logic [IVL_W:0]    rem_sub;
  logic              take;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  // A zero divisor always fits, so the quotient comes out all ones.
  assign rem_sh  = {rem_q, quo_q[QUO_W-1]};
  assign take    = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(QUO_W - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = take ? rem_sub[IVL_W-1:0] : rem_sh[IVL_W-1:0];
      quo_d  = {quo_q[QUO_W-2:0], take};
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- src/prd_back.sv -----
module prd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  prd_pkg::cfg_t              cfg_i,
  input  logic                       fifo_empty_i,
  output logic                       pop_o,
  input  logic [prd_pkg::SUM_W-1:0]  pop_data_i,
  output prd_pkg::div_req_t          div_req_o,
  input  prd_pkg::div_rsp_t          div_rsp_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [prd_pkg::SMP_W-1:0]  conditioned_sample_o,
  output logic                       pulse_level_o,
  output logic                       beat_o,
  output logic                       rate_updated_o,
  output logic [prd_pkg::BPM_W-1:0]  bpm_o
);
  import prd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_MULT = 4'b0100,
    ST_RATE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Detector state
  logic [SMP_W-1:0]  mean_q, mean_d;
  logic [SMP_W-1:0]  cur_q, cur_d;
  logic [WIN_W-1:0]  fill_q, fill_d;
  logic [SMP_W-1:0]  high_q, high_d;
  logic [SMP_W-1:0]  low_q, low_d;
  logic [SMP_W-1:0]  mid_q, mid_d;
  logic [JUMP_W-1:0] jump_q, jump_d;
  logic              pulse_q, pulse_d;
  logic              parity_q, parity_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [TICK_W-1:0] first_q, first_d;
  logic [TICK_W-1:0] diff_q, diff_d;
  logic [BPM_W-1:0]  bpm_q, bpm_d;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic              beat_q, beat_d;
  logic              upd_q, upd_d;

  // Tick evaluation
  logic              slot_free;
  logic signed [SMP_W:0] rise;
  logic              win_take;
  logic [SMP_W-1:0]  high_n, low_n;
  logic [WIN_W-1:0]  fill_n;
  logic              win_done;
  logic [SMP_W:0]    span_sum;
  logic [SMP_W-1:0]  span;
  logic [SMP_W-1:0]  mid_n;
  logic [JUMP_W-1:0] jump_n;
  logic              pulse_n, beat_n, parity_n;
  logic              second_beat, rate_go;

  // Rate clamp
  logic [BPM_W-1:0]  rate_hi, rate_clamped;

  assign slot_free = ~out_valid_q | out_ready_i;

  // Window gate: only a rise below the jump limit joins the window
  assign rise     = $signed({1'b0, mean_q}) - $signed({1'b0, cur_q});
  assign win_take = (rise < $signed({2'b00, jump_q}));
  assign high_n   = (win_take && mean_q > high_q) ? mean_q : high_q;
  assign low_n    = (win_take && mean_q < low_q) ? mean_q : low_q;
  assign fill_n   = fill_q + WIN_W'(win_take);
  assign win_done = (fill_n >= WIN_W'(WINDOW));

  // Refresh midpoint and jump limit at the end of a window
  assign span_sum = {1'b0, high_n} + {1'b0, low_n};
  assign span     = high_n - low_n;
  assign mid_n    = win_done ? span_sum[SMP_W:1] : mid_q;
  assign jump_n   = win_done ? span[SMP_W-1:1] : jump_q;

  // Beat detection on rising crossings of the midpoint
  assign pulse_n     = (mean_q > mid_n);
  assign beat_n      = ~pulse_q & pulse_n;
  assign parity_n    = parity_q ^ beat_n;
  assign second_beat = beat_n & ~parity_n;
  assign rate_go     = second_beat & (tick_q > first_q);

  // Ceiling first, then floor
  assign rate_hi      = (div_rsp_i.quotient > QUO_W'(cfg_i.bpm_ceiling)) ?
                        cfg_i.bpm_ceiling : div_rsp_i.quotient[BPM_W-1:0];
  assign rate_clamped = (rate_hi < cfg_i.bpm_floor) ? cfg_i.bpm_floor : rate_hi;

  always_comb begin
    state_d     = state_q;
    mean_d      = mean_q;
    cur_d       = cur_q;
    fill_d      = fill_q;
    high_d      = high_q;
    low_d       = low_q;
    mid_d       = mid_q;
    jump_d      = jump_q;
    pulse_d     = pulse_q;
    parity_d    = parity_q;
    tick_d      = tick_q;
    first_d     = first_q;
    diff_d      = diff_q;
    bpm_d       = bpm_q;
    beat_d      = beat_q;
    upd_d       = upd_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    pop_o       = 1'b0;
    div_req_o   = '0;

    case (state_q)
      // Pull a group numerator; the trimmed-mean divisor is a power of two
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o   = 1'b1;
          mean_d  = SMP_W'(pop_data_i / SUM_W'(TRIM_DIV));
          state_d = ST_EVAL;
        end
      end
      // Commit the tick once the result register can take it
      ST_EVAL: begin
        if (slot_free) begin
          cur_d    = mean_q;
          high_d   = win_done ? '0 : high_n;
          low_d    = win_done ? SMP_W'(ADC_MAX) : low_n;
          fill_d   = win_done ? '0 : fill_n;
          mid_d    = mid_n;
          jump_d   = jump_n;
          pulse_d  = pulse_n;
          parity_d = parity_n;
          if (beat_n && parity_n) begin
            first_d = tick_q;
          end
          tick_d = second_beat ? TICK_W'(1) : tick_q + TICK_W'(1);
          diff_d = tick_q - first_q;
          beat_d = beat_n;
          upd_d  = 1'b0;
          if (rate_go) begin
            state_d = ST_MULT;
          end else begin
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      // Interval in ms straight into the divider's divisor register
      ST_MULT: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = QUO_W'(MS_PER_MIN);
        div_req_o.divisor  = {{MS_W{1'b0}}, diff_q} * {{TICK_W{1'b0}}, cfg_i.tick_ms};
        state_d            = ST_RATE;
      end
      ST_RATE: begin
        if (div_rsp_i.done) begin
          bpm_d       = rate_clamped;
          upd_d       = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      fill_q      <= '0;
      high_q      <= '0;
      low_q       <= SMP_W'(ADC_MAX);
      mid_q       <= '0;
      jump_q      <= '0;
      pulse_q     <= 1'b0;
      parity_q    <= 1'b0;
      tick_q      <= '0;
      first_q     <= '0;
      bpm_q       <= '0;
      out_valid_q <= 1'b0;
      beat_q      <= 1'b0;
      upd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      fill_q      <= fill_d;
      high_q      <= high_d;
      low_q       <= low_d;
      mid_q       <= mid_d;
      jump_q      <= jump_d;
      pulse_q     <= pulse_d;
      parity_q    <= parity_d;
      tick_q      <= tick_d;
      first_q     <= first_d;
      bpm_q       <= bpm_d;
      out_valid_q <= out_valid_d;
      beat_q      <= beat_d;
      upd_q       <= upd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d;
    diff_q <= diff_d;
  end

  assign out_valid_o          = out_valid_q;
  assign conditioned_sample_o = cur_q;
  assign pulse_level_o        = pulse_q;
  assign beat_o               = beat_q;
  assign rate_updated_o       = upd_q;
  assign bpm_o                = bpm_q;

  // Window never holds a full count between ticks
  a_fill_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < WIN_W'(WINDOW))
    else $error("window fill reached its limit without a refresh");

  a_win_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != '0 |-> high_q >= low_q)
    else $error("window high below window low");

  a_upd_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && upd_q |-> beat_q)
    else $error("rate update without a beat");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> state_q == ST_RATE)
    else $error("divider finished with nobody waiting");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EVAL || $past(state_q) == ST_RATE)
    else $error("result raised outside evaluation or rate step");

endmodule

// ----- src/pulse_rate_detector_core.sv -----
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   adc_sample_i
// out      out_valid_o / out_ready_i conditioned_sample_o, pulse_level_o, beat_o,
//                                    rate_updated_o, bpm_o
// cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Raw samples are taken one per cycle while the four-entry group queue has room.
// Each group takes the back through a pop, with the trimmed mean taken as a
// shift, and then an evaluate step; a tick that closes a beat interval adds the
// multiply and the 16-step 60000/interval divide.
// Reset is asynchronous, active low; no clearing pass, ready right after reset.
// A stalled result holds the back, the queue fills, and then in_ready_o drops.
module pulse_rate_detector_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [prd_pkg::SMP_W-1:0]       adc_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [prd_pkg::SMP_W-1:0]       conditioned_sample_o,
  output logic                            pulse_level_o,
  output logic                            beat_o,
  output logic                            rate_updated_o,
  output logic [prd_pkg::BPM_W-1:0]       bpm_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [prd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [prd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import prd_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             fifo_full, fifo_empty;
  logic             push, pop;
  logic [SUM_W-1:0] push_data, pop_data;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Configuration registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TICK_MS:     cfg_d.tick_ms     = cfg_data_i[MS_W-1:0];
        CFG_BPM_FLOOR:   cfg_d.bpm_floor   = cfg_data_i[BPM_W-1:0];
        CFG_BPM_CEILING: cfg_d.bpm_ceiling = cfg_data_i[BPM_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_ms     <= MS_W'(TICK_MS_RST);
      cfg_q.bpm_floor   <= BPM_W'(BPM_FLOOR_RST);
      cfg_q.bpm_ceiling <= BPM_W'(BPM_CEILING_RST);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sample grouping
  prd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .adc_sample_i (adc_sample_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Group numerators waiting for the back
  prd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  // Iterative divider for the rate
  prd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Tick evaluation, beat and rate
  prd_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .fifo_empty_i         (fifo_empty),
    .pop_o                (pop),
    .pop_data_i           (pop_data),
    .div_req_o            (div_req),
    .div_rsp_i            (div_rsp),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .conditioned_sample_o (conditioned_sample_o),
    .pulse_level_o        (pulse_level_o),
    .beat_o               (beat_o),
    .rate_updated_o       (rate_updated_o),
    .bpm_o                (bpm_o)
  );

endmodule

// ----- sim/tb_pulse_rate_detector_core.sv -----
`timescale 1ns / 100ps

module tb_pulse_rate_detector_core;
  import prd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int REPORT_CAP     = 100;
  // Index past the register list, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [SMP_W-1:0] level;
    logic             high;
    logic             heartbeat;
    logic             rate_new;
    logic [BPM_W-1:0] bpm;
  } tick_result_t;

  // Stimulus side
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic [SMP_W-1:0]      adc_sample = '0;
  logic                  out_ready  = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Block outputs
  logic             in_ready;
  logic             out_valid;
  logic [SMP_W-1:0] cond_sample;
  logic             pulse_level;
  logic             beat;
  logic             rate_updated;
  logic [BPM_W-1:0] bpm;
  logic             cfg_ready;

  // Mirror of the registers, starting at their reset values
  logic [MS_W-1:0]  cfg_tick_ms     = MS_W'(TICK_MS_RST);
  logic [BPM_W-1:0] cfg_bpm_floor   = BPM_W'(BPM_FLOOR_RST);
  logic [BPM_W-1:0] cfg_bpm_ceiling = BPM_W'(BPM_CEILING_RST);

  // Mirror of the detector state
  int                grp_cnt       = 0;
  logic [SUM_W-1:0]  grp_sum       = '0;
  logic [SMP_W-1:0]  grp_lo        = SMP_W'(ADC_MAX);
  logic [SMP_W-1:0]  grp_hi        = '0;
  logic [SMP_W-1:0]  cur_tick      = '0;
  logic [SMP_W-1:0]  prev_tick     = '0;
  int                win_cnt       = 0;
  logic [SMP_W-1:0]  win_hi        = '0;
  logic [SMP_W-1:0]  win_lo        = SMP_W'(ADC_MAX);
  logic [SMP_W-1:0]  mid_level     = '0;
  logic [JUMP_W-1:0] rise_limit    = '0;
  logic              above_mid     = 1'b0;
  logic              beat_odd      = 1'b0;
  logic [TICK_W-1:0] tick_ctr      = '0;
  logic [TICK_W-1:0] first_beat_at = '0;
  logic [BPM_W-1:0]  rate_bpm      = '0;

  tick_result_t due_ticks[$];

  bit gap_on      = 1'b0;
  bit stall_on    = 1'b0;
  int stall_left  = 0;
  int quiet_cycles = 0;
  int mismatches  = 0;
  int n_samples   = 0;
  int n_ticks     = 0;
  int n_beats     = 0;
  int n_rates     = 0;
  int n_writes    = 0;

  pulse_rate_detector_core dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .adc_sample_i         (adc_sample),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .conditioned_sample_o (cond_sample),
    .pulse_level_o        (pulse_level),
    .beat_o               (beat),
    .rate_updated_o       (rate_updated),
    .bpm_o                (bpm),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Detector mirror: folds one sample in, queues the tick it completes
  task automatic advance_detector(input logic [SMP_W-1:0] s);
    int unsigned       trimmed;
    int unsigned       span;
    int unsigned       rate;
    int                rise;
    logic [TICK_W-1:0] second;
    logic              was_above;
    tick_result_t      res;
    grp_sum = grp_sum + s;
    if (s < grp_lo) grp_lo = s;
    if (s > grp_hi) grp_hi = s;
    grp_cnt++;
    if (grp_cnt == GROUP) begin
      // trimmed mean of the group
      prev_tick = cur_tick;
      trimmed = (32'(grp_sum) - 32'(grp_lo) - 32'(grp_hi)) / TRIM_DIV;
      cur_tick = trimmed[SMP_W-1:0];
      grp_cnt = 0;
      grp_sum = '0;
      grp_lo = SMP_W'(ADC_MAX);
      grp_hi = '0;

      // window admission and threshold refresh
      rise = int'(32'(cur_tick)) - int'(32'(prev_tick));
      if (rise < int'(32'(rise_limit))) begin
        if (cur_tick > win_hi) win_hi = cur_tick;
        if (cur_tick < win_lo) win_lo = cur_tick;
        win_cnt++;
      end
      if (win_cnt >= WINDOW) begin
        mid_level = SMP_W'((32'(win_hi) + 32'(win_lo)) / 2);
        rise_limit = JUMP_W'((32'(win_hi) - 32'(win_lo)) / 2);
        win_cnt = 0;
        win_hi = '0;
        win_lo = SMP_W'(ADC_MAX);
      end

      // heartbeat detection, every second one closes an interval
      was_above = above_mid;
      above_mid = cur_tick > mid_level;
      res.heartbeat = 1'b0;
      res.rate_new = 1'b0;
      if (!was_above && above_mid) begin
        res.heartbeat = 1'b1;
        beat_odd = ~beat_odd;
        if (beat_odd) begin
          first_beat_at = tick_ctr;
        end else begin
          second = tick_ctr;
          tick_ctr = '0;
          if (second > first_beat_at) begin
            span = (32'(second) - 32'(first_beat_at)) * 32'(cfg_tick_ms);
            rate = (span == 0) ? 32'hFFFF_FFFF : 32'(MS_PER_MIN) / span;
            if (rate > 32'(cfg_bpm_ceiling)) rate = 32'(cfg_bpm_ceiling);
            if (rate < 32'(cfg_bpm_floor)) rate = 32'(cfg_bpm_floor);
            rate_bpm = rate[BPM_W-1:0];
            res.rate_new = 1'b1;
          end
        end
      end
      tick_ctr = tick_ctr + 1'b1;

      res.level = cur_tick;
      res.high = above_mid;
      res.bpm = rate_bpm;
      due_ticks.push_back(res);
      n_ticks++;
      if (res.heartbeat) n_beats++;
      if (res.rate_new) n_rates++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gap_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SMP_W-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > ADC_MAX) return SMP_W'(ADC_MAX);
    return SMP_W'(v);
  endfunction

  // One input beat; valid stays up when the next sample follows with no gap
  task automatic send_sample(input logic [SMP_W-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_samples++;
    advance_detector(s);
  endtask

  task automatic send_group(input int centre, input int spread, input int count);
    repeat (count) begin
      send_sample(clamp_sample(centre + int'($urandom_range(0, 2 * spread)) - spread));
    end
  endtask

  // Hold input until every due tick is out, then let the back end go quiet
  task automatic quiesce(input int settle);
    in_valid <= 1'b0;
    while (due_ticks.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_writes++;
    case (idx)
      CFG_TICK_MS:     cfg_tick_ms = data[MS_W-1:0];
      CFG_BPM_FLOOR:   cfg_bpm_floor = data[BPM_W-1:0];
      CFG_BPM_CEILING: cfg_bpm_ceiling = data[BPM_W-1:0];
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input int tms, input int lo, input int hi);
    quiesce(SETTLE_CYCLES);
    write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom), 1'b0);
    write_reg(CFG_TICK_MS, CFG_DATA_W'(tms), 1'b0);
    write_reg(CFG_BPM_FLOOR, CFG_DATA_W'(lo), 1'b0);
    write_reg(CFG_BPM_CEILING, CFG_DATA_W'(hi), 1'b1);
  endtask

  // Square-ish pulse train around the learned midpoint, with noise bursts
  task automatic run_pulses(input int n_ticks_req, input int max_half);
    int  k;
    int  amp;
    int  half;
    int  centre;
    bit  high;
    k = 0;
    high = 1'b0;
    while (k < n_ticks_req) begin
      centre = (mid_level < 400) ? 2048 : int'(32'(mid_level));
      amp = $urandom_range(150, 900);
      half = $urandom_range(2, max_half);
      high = !high;
      repeat (half) begin
        if ($urandom_range(0, 11) == 0) begin
          // noise burst of random length, also shifts group alignment
          repeat ($urandom_range(1, GROUP)) send_sample(SMP_W'($urandom_range(0, ADC_MAX)));
        end else begin
          send_group(high ? centre + amp : centre - amp, $urandom_range(0, 40), GROUP);
        end
        k++;
        if ($urandom_range(0, 59) == 0) quiesce(0);
      end
    end
  endtask

  // Full-scale groups: a rise, a fall and an equal tick before any threshold
  task automatic test_sample_extremes();
    int j;
    gap_on = 1'b1;
    stall_on = 1'b1;
    repeat (GROUP) send_sample(SMP_W'(ADC_MAX));
    for (j = 0; j < GROUP; j++) send_sample(j[0] ? SMP_W'(ADC_MAX) : SMP_W'(0));
    for (j = 0; j < GROUP; j++) send_sample(j[0] ? 12'h555 : 12'hAAA);
  endtask

  // Falling ramp fills the first window so a midpoint is learned
  task automatic test_threshold_learning();
    int k;
    gap_on = 1'b1;
    stall_on = 1'b0;
    for (k = 0; k < 55; k++) send_group(3800 - 45 * k, 15, GROUP);
  endtask

  task automatic test_default_rate();
    gap_on = 1'b1;
    stall_on = 1'b1;
    run_pulses(14, 12);
  endtask

  // Register extremes, inverted limits, zero interval, truncated writes
  task automatic test_rate_clamps();
    gap_on = 1'b0;
    stall_on = 1'b0;
    program_regs(1, 0, 255);
    run_pulses(8, 3);
    gap_on = 1'b1;
    program_regs(1023, 0, 255);
    run_pulses(8, 3);
    stall_on = 1'b1;
    program_regs(1000, 255, 0);
    run_pulses(8, 3);
    program_regs(0, 40, 180);
    run_pulses(8, 3);
    gap_on = 1'b0;
    program_regs(20, 10'h3C5, 10'h2FF);
    run_pulses(8, 3);
  endtask

  task automatic test_random_settings();
    int lo;
    repeat (3) begin
      gap_on = $urandom_range(0, 1);
      stall_on = $urandom_range(0, 1);
      lo = $urandom_range(0, 120);
      program_regs($urandom_range(1, 1000), lo, $urandom_range(lo, 255));
      run_pulses(8, 4);
    end
    program_regs(TICK_MS_RST, BPM_FLOOR_RST, BPM_CEILING_RST);
  endtask

  // Result stall pattern: mostly short, a few long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Each result beat against the oldest due tick
  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP) begin
          $error("result with nothing due: conditioned_sample %0d", cond_sample);
        end
      end else begin
        want = due_ticks.pop_front();
        compare_field("conditioned_sample", want.level, cond_sample);
        compare_field("pulse_level", want.high, pulse_level);
        compare_field("beat", want.heartbeat, beat);
        compare_field("rate_updated", want.rate_new, rate_updated);
        compare_field("bpm", want.bpm, bpm);
      end
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d ticks due", quiet_cycles,
               due_ticks.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sample_extremes();
    test_threshold_learning();
    test_default_rate();
    test_rate_clamps();
    test_random_settings();

    quiesce(SETTLE_CYCLES);
    $display("Checked %0d ticks from %0d samples: %0d heartbeats, %0d rate updates, %0d writes.",
             n_ticks, n_samples, n_beats, n_rates, n_writes);
    $display("Covered full-scale samples, threshold learning, bpm clamp extremes, zero interval,");
    $display("inverted limits and an ignored register index.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
